// ===== design/assert_macros.svh =====
// Assertion macros shared by the CSR transpose block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define CSRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is active
`define CSRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/csrt_pkg.sv =====
// Shared constants, codes and controller/datapath bundles of the CSR transpose block.
// No dependencies; used by every module of the block except csrt_ram.
package csrt_pkg;

    // Sizing
    localparam int MAX_ROWS     = 256;
    localparam int MAX_ELEMENTS = 1024;
    localparam int RADDR_W      = $clog2(MAX_ROWS);          // row address
    localparam int ROW_CNT_W    = $clog2(MAX_ROWS + 1);      // row count incl. MAX_ROWS
    localparam int EADDR_W      = $clog2(MAX_ELEMENTS);      // element address
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);  // element count incl. MAX

    // Word field widths
    localparam int OP_W  = 2;
    localparam int ROW_W = 9;
    localparam int PAY_W = 64;
    localparam int IDX_W = 11;
    localparam int SRC_W = 10;
    localparam int STS_W = 2;

    // Register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_ROWS_IN_USE = '0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
    localparam logic [OP_W-1:0] OP_RD_PTR   = 2'd1;
    localparam logic [OP_W-1:0] OP_RD_ENTRY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    // Status codes
    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_ROW_RANGE = 2'd1;
    localparam logic [STS_W-1:0] STS_IDX_RANGE = 2'd2;
    localparam logic [STS_W-1:0] STS_NOT_READY = 2'd3;

    // Which memory feeds the response
    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_PTR   = 2'd1;
    localparam logic [1:0] SRC_ENTRY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;        // input word taken this cycle
        logic init_clear;    // post-reset clear of the count memory
        logic load_inc;      // count update of a loaded element
        logic pfx_run;       // prefix sum sweep
        logic scat_start;    // fetch first loaded element
        logic scat_fill_rd;  // look up fill position of current element
        logic scat_write;    // store current element in row order
        logic set_ready;     // transpose complete
        logic push;          // load the response register
    } csrt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic init_done;
        logic last;
        logic pfx_done;
        logic count_zero;
        logic scat_last;
        logic out_free;
    } csrt_sts_t;

endpackage

// ===== design/bucket_map_to_csr_transpose.sv =====
// Use: a load streams words with operation 0 (target row, payload, last); the word with
// last set closes the load and builds the row-sorted (CSR transpose) view. Operation 1
// returns the start of a row, operation 2 a sorted entry (load position and payload).
// Operation 3 is taken and gives no response word. Input and output are valid/ready
// channels; rows_in_use sits at byte address 0 of the register port.
// Steps, from acceptance to the response word in the output register:
//   load word: buffer write and row-count read, then count write;
//   read word: registered memory read, then response register;
//   last load: count write, then the prefix sweep over all 256 row counts, then, with
//   load positions held (skipped rows included), the scatter, which reads and writes
//   the fill-position memory for each element, then the ready step.
// One word is in work at a time; a new word is taken once its predecessor's response has
// entered the output register, or at once after an operation 3 word. If the output
// register still holds a word that out_ready has not taken, the finished word waits
// inside and input stalls.
// Reset: rows_in_use returns to 256, the block is in the loading phase, and a sweep
// clears all 256 row-count entries while in_ready stays low; register writes are
// taken during the sweep.
// Depends on csrt_pkg, csrt_ram, csrt_ctrl, csrt_dp and assert_macros.svh.
`include "assert_macros.svh"

module bucket_map_to_csr_transpose (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csrt_pkg::APB_AW-1:0]       paddr,
    input  logic [csrt_pkg::APB_DW-1:0]       pwdata,
    output logic [csrt_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [csrt_pkg::OP_W-1:0]         operation,
    input  logic signed [csrt_pkg::ROW_W-1:0] target_row,
    input  logic [csrt_pkg::PAY_W-1:0]        payload,
    input  logic                              last,
    input  logic [csrt_pkg::IDX_W-1:0]        read_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [csrt_pkg::STS_W-1:0]        status,
    output logic [csrt_pkg::CNT_W-1:0]        total_entries,
    output logic [csrt_pkg::CNT_W-1:0]        row_start,
    output logic [csrt_pkg::SRC_W-1:0]        source_index,
    output logic [csrt_pkg::PAY_W-1:0]        entry_payload
);

    logic [csrt_pkg::ROW_CNT_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic                           cfg_sel;
    logic                           take_load;
    logic                           take_nop;
    csrt_pkg::csrt_cmd_t            cmd;
    csrt_pkg::csrt_sts_t            sts;

    // Register port: one register, zero-wait
    assign cfg_sel = paddr[csrt_pkg::APB_AW-1:2] == csrt_pkg::REG_ROWS_IN_USE;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? csrt_pkg::APB_DW'(rows_cfg_reg) : '0;

    always_comb
    begin
        rows_cfg_next = rows_cfg_reg;
        if (psel && penable && pwrite && cfg_sel)
        begin
            rows_cfg_next = pwdata[csrt_pkg::ROW_CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= csrt_pkg::ROW_CNT_W'(csrt_pkg::MAX_ROWS);
        end
        else
        begin
            rows_cfg_reg <= rows_cfg_next;
        end
    end

    // Sequencer
    csrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Memories and arithmetic
    csrt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .rows_cfg      (rows_cfg_reg),
        .operation     (operation),
        .target_row    (target_row),
        .payload       (payload),
        .last          (last),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .total_entries (total_entries),
        .row_start     (row_start),
        .source_index  (source_index),
        .entry_payload (entry_payload)
    );

    // Accepted words of each kind, for the checks below
    assign take_load = in_valid && in_ready && (operation == csrt_pkg::OP_LOAD);
    assign take_nop  = in_valid && in_ready && (operation == csrt_pkg::OP_NONE);

    // A load word always needs the count write cycle before the next word
    `CSRT_ASSERT_NXT(a_load_blocks_input, clk, rst_n, take_load, !in_ready)
    // A word with no response leaves the block ready again at once
    `CSRT_ASSERT_NXT(a_nop_no_stall, clk, rst_n, take_nop, in_ready)
    // A response word is only produced by the sequencer while input is held off
    `CSRT_ASSERT_IMP(a_push_while_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

// ===== design/csrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/csrt_ctrl.sv =====
// Sequencer of the CSR transpose block: load, count, prefix, scatter and read steps.
// Depends on csrt_pkg.
module csrt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [csrt_pkg::OP_W-1:0] operation,
    output logic                   in_ready,
    input  csrt_pkg::csrt_sts_t    sts,
    output csrt_pkg::csrt_cmd_t    cmd
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOADW = 4'd2;
    localparam logic [3:0] S_PFX   = 4'd3;
    localparam logic [3:0] S_SCRD  = 4'd4;
    localparam logic [3:0] S_SCF   = 4'd5;
    localparam logic [3:0] S_SCW   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_RESP  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_clear = 1'b1;
                if (sts.init_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (operation)
                        csrt_pkg::OP_LOAD:     state_next = S_LOADW;
                        csrt_pkg::OP_RD_PTR:   state_next = S_RESP;
                        csrt_pkg::OP_RD_ENTRY: state_next = S_RESP;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_LOADW:
            begin
                cmd.load_inc = 1'b1;
                state_next   = sts.last ? S_PFX : S_RESP;
            end
            S_PFX:
            begin
                cmd.pfx_run = 1'b1;
                if (sts.pfx_done)
                begin
                    state_next = sts.count_zero ? S_FIN : S_SCRD;
                end
            end
            S_SCRD:
            begin
                cmd.scat_start = 1'b1;
                state_next     = S_SCF;
            end
            S_SCF:
            begin
                cmd.scat_fill_rd = 1'b1;
                state_next       = S_SCW;
            end
            S_SCW:
            begin
                cmd.scat_write = 1'b1;
                state_next     = sts.scat_last ? S_FIN : S_SCF;
            end
            S_FIN:
            begin
                cmd.set_ready = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/csrt_dp.sv =====
// Datapath of the CSR transpose block: element buffer, row counts, row pointers,
// fill positions, sorted entries and the response register. Depends on csrt_pkg, csrt_ram.
module csrt_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  csrt_pkg::csrt_cmd_t              cmd,
    output csrt_pkg::csrt_sts_t              sts,
    input  logic [csrt_pkg::ROW_CNT_W-1:0]   rows_cfg,
    input  logic [csrt_pkg::OP_W-1:0]        operation,
    input  logic signed [csrt_pkg::ROW_W-1:0] target_row,
    input  logic [csrt_pkg::PAY_W-1:0]       payload,
    input  logic                             last,
    input  logic [csrt_pkg::IDX_W-1:0]       read_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [csrt_pkg::STS_W-1:0]       status,
    output logic [csrt_pkg::CNT_W-1:0]       total_entries,
    output logic [csrt_pkg::CNT_W-1:0]       row_start,
    output logic [csrt_pkg::SRC_W-1:0]       source_index,
    output logic [csrt_pkg::PAY_W-1:0]       entry_payload
);

    localparam int RADDR_W   = csrt_pkg::RADDR_W;
    localparam int ROW_CNT_W = csrt_pkg::ROW_CNT_W;
    localparam int EADDR_W   = csrt_pkg::EADDR_W;
    localparam int CNT_W     = csrt_pkg::CNT_W;
    localparam int ROW_W     = csrt_pkg::ROW_W;
    localparam int PAY_W     = csrt_pkg::PAY_W;
    localparam int IDX_W     = csrt_pkg::IDX_W;
    localparam int SRC_W     = csrt_pkg::SRC_W;
    localparam int STS_W     = csrt_pkg::STS_W;

    // Control state
    logic                 phase_ready_reg, phase_ready_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ROW_CNT_W-1:0] comp_rows_reg, comp_rows_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [ROW_CNT_W-1:0] work_idx_reg, work_idx_next;
    logic                 pfx_vld_reg, pfx_vld_next;
    logic                 out_valid_reg, out_valid_next;

    // Working and payload registers
    logic                 last_reg, last_next;
    logic                 counted_reg, counted_next;
    logic [RADDR_W-1:0]   cnt_row_reg, cnt_row_next;
    logic [STS_W-1:0]     res_status_reg, res_status_next;
    logic [1:0]           res_src_reg, res_src_next;
    logic                 show_total_reg, show_total_next;
    logic [RADDR_W-1:0]   pfx_addr_reg, pfx_addr_next;
    logic [CNT_W-1:0]     acc_reg, acc_next;
    logic [EADDR_W-1:0]   scat_idx_reg, scat_idx_next;
    logic [STS_W-1:0]     out_status_reg, out_status_next;
    logic [CNT_W-1:0]     out_total_reg, out_total_next;
    logic [CNT_W-1:0]     out_rstart_reg, out_rstart_next;
    logic [SRC_W-1:0]     out_src_reg, out_src_next;
    logic [PAY_W-1:0]     out_pay_reg, out_pay_next;

    // Memory ports
    logic                     cnt_we, cnt_re;
    logic [RADDR_W-1:0]       cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]         cnt_wdata, cnt_rdata;
    logic                     fill_we, fill_re;
    logic [RADDR_W-1:0]       fill_waddr, fill_raddr;
    logic [CNT_W-1:0]         fill_wdata, fill_rdata;
    logic                     ptr_we, ptr_re;
    logic [RADDR_W-1:0]       ptr_waddr, ptr_raddr;
    logic [CNT_W-1:0]         ptr_wdata, ptr_rdata;
    logic                     ld_we, ld_re;
    logic [EADDR_W-1:0]       ld_waddr, ld_raddr;
    logic [ROW_W+PAY_W-1:0]   ld_wdata, ld_rdata;
    logic                     srt_we, srt_re;
    logic [EADDR_W-1:0]       srt_waddr, srt_raddr;
    logic [SRC_W+PAY_W-1:0]   srt_wdata, srt_rdata;

    // Decode helpers
    logic [ROW_CNT_W-1:0] eff_rows;
    logic [CNT_W-1:0]     base_pos;
    logic                 buf_full;
    logic                 row_neg;
    logic                 row_ok;
    logic                 row_store;
    logic                 row_counted;
    logic                 pfx_in_use;
    logic [CNT_W-1:0]     pfx_sum;
    logic [ROW_W-1:0]     scat_row;
    logic                 scat_keep;
    logic [IDX_W-1:0]     ridx_m1;

    // Row counts per row, cleared after reset and during every prefix sweep
    csrt_ram #(.WIDTH(CNT_W), .DEPTH(csrt_pkg::MAX_ROWS)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    // Next free slot of each row during the scatter
    csrt_ram #(.WIDTH(CNT_W), .DEPTH(csrt_pkg::MAX_ROWS)) u_fill_ram (
        .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
        .re(fill_re), .raddr(fill_raddr), .rdata(fill_rdata)
    );

    // Entry r holds the end of row r, which is the start of row r+1
    csrt_ram #(.WIDTH(CNT_W), .DEPTH(csrt_pkg::MAX_ROWS)) u_ptr_ram (
        .clk(clk), .we(ptr_we), .waddr(ptr_waddr), .wdata(ptr_wdata),
        .re(ptr_re), .raddr(ptr_raddr), .rdata(ptr_rdata)
    );

    // Loaded elements: {row, payload}
    csrt_ram #(.WIDTH(ROW_W + PAY_W), .DEPTH(csrt_pkg::MAX_ELEMENTS)) u_ld_ram (
        .clk(clk), .we(ld_we), .waddr(ld_waddr), .wdata(ld_wdata),
        .re(ld_re), .raddr(ld_raddr), .rdata(ld_rdata)
    );

    // Sorted entries: {load position, payload}
    csrt_ram #(.WIDTH(SRC_W + PAY_W), .DEPTH(csrt_pkg::MAX_ELEMENTS)) u_srt_ram (
        .clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
        .re(srt_re), .raddr(srt_raddr), .rdata(srt_rdata)
    );

    // Decode of the word and of the memory outputs
    always_comb
    begin
        if (rows_cfg == '0)
        begin
            eff_rows = ROW_CNT_W'(1);
        end
        else if (rows_cfg > ROW_CNT_W'(csrt_pkg::MAX_ROWS))
        begin
            eff_rows = ROW_CNT_W'(csrt_pkg::MAX_ROWS);
        end
        else
        begin
            eff_rows = rows_cfg;
        end

        // a load after a finished transpose starts over at position zero
        base_pos    = phase_ready_reg ? '0 : count_reg;
        buf_full    = base_pos >= CNT_W'(csrt_pkg::MAX_ELEMENTS);
        row_neg     = target_row[ROW_W-1];
        row_ok      = row_neg ? (target_row == {ROW_W{1'b1}})
                              : ({1'b0, target_row[RADDR_W-1:0]} < eff_rows);
        row_store   = row_ok && !buf_full;
        row_counted = row_store && !row_neg;

        // rows at or above the compute-time row count add nothing
        pfx_in_use = {1'b0, pfx_addr_reg} < comp_rows_reg;
        pfx_sum    = acc_reg + (pfx_in_use ? cnt_rdata : '0);

        scat_row  = ld_rdata[PAY_W +: ROW_W];
        scat_keep = !scat_row[ROW_W-1] && ({1'b0, scat_row[RADDR_W-1:0]} < comp_rows_reg);

        ridx_m1 = read_index - IDX_W'(1);
    end

    // Register next values and memory controls
    always_comb
    begin
        phase_ready_next = phase_ready_reg;
        count_next       = count_reg;
        comp_rows_next   = comp_rows_reg;
        total_next       = total_reg;
        work_idx_next    = work_idx_reg;
        pfx_vld_next     = 1'b0;
        out_valid_next   = out_valid_reg;
        last_next        = last_reg;
        counted_next     = counted_reg;
        cnt_row_next     = cnt_row_reg;
        res_status_next  = res_status_reg;
        res_src_next     = res_src_reg;
        show_total_next  = show_total_reg;
        pfx_addr_next    = pfx_addr_reg;
        acc_next         = acc_reg;
        scat_idx_next    = scat_idx_reg;
        out_status_next  = out_status_reg;
        out_total_next   = out_total_reg;
        out_rstart_next  = out_rstart_reg;
        out_src_next     = out_src_reg;
        out_pay_next     = out_pay_reg;

        cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_re = 1'b0; cnt_raddr = '0;
        fill_we = 1'b0; fill_waddr = '0; fill_wdata = '0; fill_re = 1'b0; fill_raddr = '0;
        ptr_we = 1'b0; ptr_waddr = '0; ptr_wdata = '0; ptr_re = 1'b0; ptr_raddr = '0;
        ld_we = 1'b0; ld_waddr = '0; ld_wdata = '0; ld_re = 1'b0; ld_raddr = '0;
        srt_we = 1'b0; srt_waddr = '0; srt_wdata = '0; srt_re = 1'b0; srt_raddr = '0;

        // clearing sweep of the count memory after reset
        if (cmd.init_clear)
        begin
            cnt_we        = 1'b1;
            cnt_waddr     = work_idx_reg[RADDR_W-1:0];
            work_idx_next = work_idx_reg + ROW_CNT_W'(1);
        end

        // word accepted
        if (cmd.accept)
        begin
            work_idx_next = '0;
            acc_next      = '0;
            case (operation)
                csrt_pkg::OP_LOAD:
                begin
                    phase_ready_next = 1'b0;
                    last_next        = last;
                    counted_next     = row_counted;
                    cnt_row_next     = target_row[RADDR_W-1:0];
                    show_total_next  = last;
                    res_src_next     = csrt_pkg::SRC_NONE;
                    if (!row_ok)
                    begin
                        res_status_next = csrt_pkg::STS_ROW_RANGE;
                    end
                    else if (buf_full)
                    begin
                        res_status_next = csrt_pkg::STS_IDX_RANGE;
                    end
                    else
                    begin
                        res_status_next = csrt_pkg::STS_OK;
                    end
                    ld_we      = row_store;
                    ld_waddr   = base_pos[EADDR_W-1:0];
                    ld_wdata   = {target_row, payload};
                    count_next = row_store ? base_pos + CNT_W'(1) : base_pos;
                    // count read; the increment lands in the next cycle
                    cnt_re     = row_counted;
                    cnt_raddr  = target_row[RADDR_W-1:0];
                end
                csrt_pkg::OP_RD_PTR:
                begin
                    res_src_next    = csrt_pkg::SRC_NONE;
                    show_total_next = phase_ready_reg;
                    if (!phase_ready_reg)
                    begin
                        res_status_next = csrt_pkg::STS_NOT_READY;
                    end
                    else if (read_index > IDX_W'(comp_rows_reg))
                    begin
                        res_status_next = csrt_pkg::STS_IDX_RANGE;
                    end
                    else
                    begin
                        res_status_next = csrt_pkg::STS_OK;
                        // row zero always starts at zero
                        if (read_index != '0)
                        begin
                            res_src_next = csrt_pkg::SRC_PTR;
                            ptr_re       = 1'b1;
                            ptr_raddr    = ridx_m1[RADDR_W-1:0];
                        end
                    end
                end
                csrt_pkg::OP_RD_ENTRY:
                begin
                    res_src_next    = csrt_pkg::SRC_NONE;
                    show_total_next = phase_ready_reg;
                    if (!phase_ready_reg)
                    begin
                        res_status_next = csrt_pkg::STS_NOT_READY;
                    end
                    else if (read_index >= total_reg)
                    begin
                        res_status_next = csrt_pkg::STS_IDX_RANGE;
                    end
                    else
                    begin
                        res_status_next = csrt_pkg::STS_OK;
                        res_src_next    = csrt_pkg::SRC_ENTRY;
                        srt_re          = 1'b1;
                        srt_raddr       = read_index[EADDR_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end

        // count update of the element just loaded
        if (cmd.load_inc)
        begin
            if (counted_reg)
            begin
                cnt_we    = 1'b1;
                cnt_waddr = cnt_row_reg;
                cnt_wdata = cnt_rdata + CNT_W'(1);
            end
            if (last_reg)
            begin
                comp_rows_next = eff_rows;
            end
        end

        // prefix sweep: read one count a cycle, sum it in the next cycle
        if (cmd.pfx_run)
        begin
            if (work_idx_reg < ROW_CNT_W'(csrt_pkg::MAX_ROWS))
            begin
                cnt_re        = 1'b1;
                cnt_raddr     = work_idx_reg[RADDR_W-1:0];
                work_idx_next = work_idx_reg + ROW_CNT_W'(1);
                pfx_vld_next  = 1'b1;
                pfx_addr_next = work_idx_reg[RADDR_W-1:0];
            end
            if (pfx_vld_reg)
            begin
                ptr_we     = 1'b1;
                ptr_waddr  = pfx_addr_reg;
                ptr_wdata  = pfx_sum;
                fill_we    = 1'b1;
                fill_waddr = pfx_addr_reg;
                fill_wdata = acc_reg;
                cnt_we     = 1'b1;
                cnt_waddr  = pfx_addr_reg;
                acc_next   = pfx_sum;
                total_next = pfx_sum;
            end
        end

        // scatter: fetch element, look up fill slot, write entry
        if (cmd.scat_start)
        begin
            ld_re         = 1'b1;
            scat_idx_next = '0;
        end
        if (cmd.scat_fill_rd)
        begin
            fill_re    = 1'b1;
            fill_raddr = scat_row[RADDR_W-1:0];
        end
        if (cmd.scat_write)
        begin
            if (scat_keep)
            begin
                srt_we     = 1'b1;
                srt_waddr  = fill_rdata[EADDR_W-1:0];
                srt_wdata  = {scat_idx_reg, ld_rdata[PAY_W-1:0]};
                fill_we    = 1'b1;
                fill_waddr = scat_row[RADDR_W-1:0];
                fill_wdata = fill_rdata + CNT_W'(1);
            end
            scat_idx_next = scat_idx_reg + EADDR_W'(1);
            ld_re         = 1'b1;
            ld_raddr      = scat_idx_reg + EADDR_W'(1);
        end

        if (cmd.set_ready)
        begin
            phase_ready_next = 1'b1;
        end

        // response register
        if (cmd.push)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_total_next  = show_total_reg ? total_reg : '0;
            out_rstart_next = (res_src_reg == csrt_pkg::SRC_PTR) ? ptr_rdata : '0;
            out_src_next    = (res_src_reg == csrt_pkg::SRC_ENTRY)
                              ? srt_rdata[PAY_W +: SRC_W] : '0;
            out_pay_next    = (res_src_reg == csrt_pkg::SRC_ENTRY)
                              ? srt_rdata[PAY_W-1:0] : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ready_reg <= 1'b0;
            count_reg       <= '0;
            comp_rows_reg   <= ROW_CNT_W'(1);
            total_reg       <= '0;
            work_idx_reg    <= '0;
            pfx_vld_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_ready_reg <= phase_ready_next;
            count_reg       <= count_next;
            comp_rows_reg   <= comp_rows_next;
            total_reg       <= total_next;
            work_idx_reg    <= work_idx_next;
            pfx_vld_reg     <= pfx_vld_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        counted_reg    <= counted_next;
        cnt_row_reg    <= cnt_row_next;
        res_status_reg <= res_status_next;
        res_src_reg    <= res_src_next;
        show_total_reg <= show_total_next;
        pfx_addr_reg   <= pfx_addr_next;
        acc_reg        <= acc_next;
        scat_idx_reg   <= scat_idx_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
        out_rstart_reg <= out_rstart_next;
        out_src_reg    <= out_src_next;
        out_pay_reg    <= out_pay_next;
    end

    // Status toward the controller
    always_comb
    begin
        sts.init_done  = work_idx_reg == ROW_CNT_W'(csrt_pkg::MAX_ROWS - 1);
        sts.last       = last_reg;
        sts.pfx_done   = pfx_vld_reg && (pfx_addr_reg == RADDR_W'(csrt_pkg::MAX_ROWS - 1));
        sts.count_zero = count_reg == '0;
        sts.scat_last  = {1'b0, scat_idx_reg} == (count_reg - CNT_W'(1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign total_entries = out_total_reg;
    assign row_start     = out_rstart_reg;
    assign source_index  = out_src_reg;
    assign entry_payload = out_pay_reg;

endmodule

// ===== verif/bucket_map_to_csr_transpose_tb.sv =====
// Self-checking testbench for bucket_map_to_csr_transpose: directed words, then random loads
// and reads checked word by word against a CSR transpose predictor kept in the testbench.
// Depends on csrt_pkg and the block's RTL only.
module bucket_map_to_csr_transpose_tb;
    import csrt_pkg::*;

    localparam int ITEMS_TARGET = 1450;
    localparam int TAIL_START   = ITEMS_TARGET - 150;
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int DIR_ROWS     = 24;

    // One response word
    typedef struct packed {
        logic [STS_W-1:0] st;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] rstart;
        logic [SRC_W-1:0] src;
        logic [PAY_W-1:0] pay;
    } resp_t;

    // Directed row; a typed row expects its status with every other field zero
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [ROW_W-1:0] row;
        logic [PAY_W-1:0]        pay;
        logic                    lst;
        logic [IDX_W-1:0]        idx;
        logic                    typed;
        logic [STS_W-1:0]        want_st;
    } vec_t;

    localparam logic [PAY_W-1:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Rows are 9-bit two's complement: 9'h100 is -256, 9'h1FF is -1 (skip), 9'h1FE is -2
    localparam vec_t DIR_TBL [0:DIR_ROWS-1] = '{
        '{OP_RD_PTR,   9'h000, 64'h0,                 1'b0, 11'd0,    1'b1, STS_NOT_READY},
        '{OP_RD_ENTRY, 9'h000, 64'h0,                 1'b0, 11'd1024, 1'b1, STS_NOT_READY},
        '{OP_NONE,     9'h1FF, ONES,                  1'b1, 11'h7FF,  1'b0, STS_OK},
        '{OP_LOAD,     9'h100, ONES,                  1'b0, 11'd0,    1'b1, STS_ROW_RANGE},
        '{OP_LOAD,     9'h0FF, ONES,                  1'b0, 11'd0,    1'b1, STS_OK},
        '{OP_LOAD,     9'h000, 64'h0,                 1'b0, 11'd0,    1'b1, STS_OK},
        '{OP_LOAD,     9'h1FF, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 11'd0,  1'b1, STS_OK},
        '{OP_LOAD,     9'h0FF, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 11'd0,  1'b1, STS_OK},
        '{OP_LOAD,     9'h003, 64'h0123_4567_89AB_CDEF, 1'b0, 11'd0,  1'b1, STS_OK},
        '{OP_LOAD,     9'h000, 64'h8000_0000_0000_0001, 1'b1, 11'd0,  1'b0, STS_OK},
        '{OP_RD_PTR,   9'h000, 64'h0,                 1'b0, 11'd0,    1'b0, STS_OK},
        '{OP_RD_PTR,   9'h000, 64'h0,                 1'b0, 11'd4,    1'b0, STS_OK},
        '{OP_RD_PTR,   9'h000, 64'h0,                 1'b0, 11'd256,  1'b0, STS_OK},
        '{OP_RD_PTR,   9'h000, 64'h0,                 1'b0, 11'd257,  1'b0, STS_OK},
        '{OP_RD_PTR,   9'h000, 64'h0,                 1'b0, 11'h7FF,  1'b0, STS_OK},
        '{OP_RD_ENTRY, 9'h000, 64'h0,                 1'b0, 11'd0,    1'b0, STS_OK},
        '{OP_RD_ENTRY, 9'h000, 64'h0,                 1'b0, 11'd4,    1'b0, STS_OK},
        '{OP_RD_ENTRY, 9'h000, 64'h0,                 1'b0, 11'd5,    1'b0, STS_OK},
        '{OP_RD_ENTRY, 9'h000, 64'h0,                 1'b0, 11'd1024, 1'b0, STS_OK},
        '{OP_LOAD,     9'h1FE, 64'h0,                 1'b1, 11'd0,    1'b1, STS_ROW_RANGE},
        '{OP_RD_ENTRY, 9'h000, 64'h0,                 1'b0, 11'd0,    1'b1, STS_IDX_RANGE},
        '{OP_RD_PTR,   9'h000, 64'h0,                 1'b0, 11'd256,  1'b1, STS_OK},
        '{OP_LOAD,     9'h0FF, ONES,                  1'b1, 11'd0,    1'b0, STS_OK},
        '{OP_RD_ENTRY, 9'h000, 64'h0,                 1'b0, 11'd0,    1'b0, STS_OK}
    };

    // Block signals
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_AW-1:0]         paddr = '0;
    logic [APB_DW-1:0]         pwdata = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [OP_W-1:0]           operation = OP_NONE;
    logic signed [ROW_W-1:0]   target_row = '0;
    logic [PAY_W-1:0]          payload = '0;
    logic                      last = 1'b0;
    logic [IDX_W-1:0]          read_index = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b1;
    logic [STS_W-1:0]          status;
    logic [CNT_W-1:0]          total_entries;
    logic [CNT_W-1:0]          row_start;
    logic [SRC_W-1:0]          source_index;
    logic [PAY_W-1:0]          entry_payload;

    // Predictor copy of the block's state
    int               rows_cfg = MAX_ROWS;
    int               elem_row [MAX_ELEMENTS];
    logic [PAY_W-1:0] elem_pay [MAX_ELEMENTS];
    int               row_ptr [MAX_ROWS+2];
    int               sorted_src [MAX_ELEMENTS];
    logic [PAY_W-1:0] sorted_pay [MAX_ELEMENTS];
    int               n_held = 0;
    bit               is_sorted = 1'b0;
    int               comp_rows = 1;

    resp_t pending_responses [$];
    int    words_sent = 0;
    int    fail_cnt = 0;
    int    cycle_cnt = 0;
    int    gap_pct = 20;
    int    stall_pct = 20;
    int    ready_hold = 0;

    bucket_map_to_csr_transpose dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Row count in force: 0 acts as 1, anything above MAX_ROWS as MAX_ROWS
    function automatic int active_rows();
        if (rows_cfg < 1)
            return 1;
        if (rows_cfg > MAX_ROWS)
            return MAX_ROWS;
        return rows_cfg;
    endfunction

    // Updates the predicted state for one word; returns 1 when a response word follows
    function automatic bit predict_response(input logic [OP_W-1:0] op,
            input logic signed [ROW_W-1:0] row, input logic [PAY_W-1:0] pay,
            input logic lst, input logic [IDX_W-1:0] idx, output resp_t w);
        int fill [MAX_ROWS];
        int rows, r, t, p, i;
        w = '0;
        r = row;
        if (op == OP_NONE)
            return 1'b0;
        if (op == OP_LOAD)
        begin
            // a load after a finished transpose starts over
            if (is_sorted)
            begin
                is_sorted = 1'b0;
                n_held = 0;
            end
            if (r < -1 || r >= active_rows())
                w.st = STS_ROW_RANGE;
            else if (n_held >= MAX_ELEMENTS)
                w.st = STS_IDX_RANGE;
            else
            begin
                elem_row[n_held] = r;
                elem_pay[n_held] = pay;
                n_held++;
            end
            if (lst)
            begin
                // count per row, prefix sum, stable scatter; rows now out of range are skipped
                rows = active_rows();
                for (i = 0; i < MAX_ROWS + 2; i++)
                    row_ptr[i] = 0;
                for (i = 0; i < n_held; i++)
                begin
                    t = elem_row[i];
                    if (t >= 0 && t < rows)
                        row_ptr[t+1]++;
                end
                for (i = 1; i <= rows; i++)
                    row_ptr[i] += row_ptr[i-1];
                for (i = 0; i < rows; i++)
                    fill[i] = row_ptr[i];
                for (i = 0; i < n_held; i++)
                begin
                    t = elem_row[i];
                    if (t >= 0 && t < rows)
                    begin
                        p = fill[t];
                        fill[t]++;
                        sorted_src[p] = i;
                        sorted_pay[p] = elem_pay[i];
                    end
                end
                comp_rows = rows;
                is_sorted = 1'b1;
                w.total = CNT_W'(row_ptr[comp_rows]);
            end
        end
        else if (!is_sorted)
            w.st = STS_NOT_READY;
        else
        begin
            w.total = CNT_W'(row_ptr[comp_rows]);
            if (op == OP_RD_PTR)
            begin
                if (idx > comp_rows)
                    w.st = STS_IDX_RANGE;
                else
                    w.rstart = CNT_W'(row_ptr[idx]);
            end
            else if (idx >= row_ptr[comp_rows])
                w.st = STS_IDX_RANGE;
            else
            begin
                w.src = SRC_W'(sorted_src[idx]);
                w.pay = sorted_pay[idx];
            end
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
            input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // Drive one word, with an optional gap before it; wait for acceptance and predict
    task automatic send_word(input logic [OP_W-1:0] op, input logic signed [ROW_W-1:0] row,
            input logic [PAY_W-1:0] pay, input logic lst, input logic [IDX_W-1:0] idx,
            input logic typed, input logic [STS_W-1:0] want_st);
        resp_t w;
        resp_t typed_w;
        bit has;
        if (words_sent >= TAIL_START)
        begin
            gap_pct = 0;
            stall_pct = 0;
        end
        @(negedge clk);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        target_row <= row;
        payload <= pay;
        last <= lst;
        read_index <= idx;
        do @(posedge clk); while (!in_ready);
        has = predict_response(op, row, pay, lst, idx, w);
        if (has)
        begin
            typed_w = '0;
            typed_w.st = want_st;
            pending_responses.push_back(typed ? typed_w : w);
            words_sent++;
        end
    endtask

    // Drop valid and let the block drain before touching the register
    task automatic settle();
        @(negedge clk) in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_rows(input int unsigned value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ROWS_IN_USE, 2'b00};
        pwdata <= value & 32'h1FF;
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rows_cfg = value & 32'h1FF;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Receiver stalls in bursts of random length
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (stall_pct > 0 && $urandom_range(99) < stall_pct)
        begin
            out_ready <= 1'b0;
            ready_hold <= $urandom_range(8, 0);
        end
        else
            out_ready <= 1'b1;
    end

    // Response checker
    always @(posedge clk)
    begin
        resp_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: response word with none expected, status %0d", $time, status);
                fail_cnt++;
            end
            else
            begin
                w = pending_responses.pop_front();
                check_field("status", w.st, status);
                check_field("total_entries", w.total, total_entries);
                check_field("row_start", w.rstart, row_start);
                check_field("source_index", w.src, source_index);
                check_field("entry_payload", w.pay, entry_payload);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d responses outstanding", $time,
                     pending_responses.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int ph, k, i, sel, sel2, n_elems, n_reads, tot;
        bit full_run;
        logic [OP_W-1:0] op;
        logic signed [ROW_W-1:0] row;
        logic [PAY_W-1:0] pay;
        logic lst;
        logic [IDX_W-1:0] idx;

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed words at the reset row count
        for (i = 0; i < DIR_ROWS; i++)
            send_word(DIR_TBL[i].op, DIR_TBL[i].row, DIR_TBL[i].pay, DIR_TBL[i].lst,
                      DIR_TBL[i].idx, DIR_TBL[i].typed, DIR_TBL[i].want_st);

        // Random phases: optional row count change, one load, then reads
        ph = 0;
        while (words_sent < ITEMS_TARGET)
        begin
            // no idling at all in the closing stretch
            if (words_sent < TAIL_START)
            begin
                gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
                stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
            end
            else
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            settle();
            if (ph < 8 || $urandom_range(3) != 0)
            begin
                case (ph % 8)
                    0: write_rows(1);
                    1: write_rows(0);
                    2: write_rows(511);
                    3: write_rows(256);
                    4: write_rows(2);
                    5: write_rows(257);
                    6: write_rows(255);
                    default: write_rows($urandom_range(511, 0));
                endcase
            end

            // one phase fills the load buffer and runs past it
            full_run = (ph == 2);
            n_elems = full_run ? MAX_ELEMENTS + 6 : $urandom_range(24, 1);
            for (k = 0; k < n_elems; k++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    // noise: op 3 or a read in the middle of the load
                    send_word(2'($urandom_range(3, 1)), 9'($urandom), {$urandom, $urandom},
                              1'($urandom), 11'($urandom), 1'b0, STS_OK);
                end
                if (!full_run && n_elems > 6 && k == n_elems / 2 && $urandom_range(3) == 0)
                begin
                    settle();
                    write_rows($urandom_range(511, 0));
                end
                sel = $urandom_range(99);
                if (full_run && k == n_elems - 3)
                    row = 9'h100;
                else if (full_run || sel < 80)
                    row = (sel % 10 == 0) ? 9'h1FF : 9'($urandom_range(active_rows() - 1, 0));
                else if (sel < 90 && active_rows() < MAX_ROWS)
                    row = 9'($urandom_range(MAX_ROWS - 1, active_rows()));
                else
                    row = 9'($urandom_range(510, 256));
                sel2 = $urandom_range(99);
                if (sel2 < 5)
                    pay = ONES;
                else if (sel2 < 10)
                    pay = '0;
                else
                    pay = {$urandom, $urandom};
                // a stray early last now and then breaks the load in two
                lst = (k == n_elems - 1) || (!full_run && $urandom_range(99) < 3);
                send_word(OP_LOAD, row, pay, lst, 11'($urandom), 1'b0, STS_OK);
            end

            n_reads = full_run ? 60 : $urandom_range(24, 4);
            for (k = 0; k < n_reads; k++)
            begin
                sel = $urandom_range(99);
                sel2 = $urandom_range(99);
                tot = row_ptr[comp_rows];
                if (sel < 45)
                begin
                    op = OP_RD_PTR;
                    if (sel2 < 70)
                        idx = 11'($urandom_range(comp_rows + 1, 0));
                    else if (sel2 < 85)
                        idx = 11'(comp_rows);
                    else if (sel2 < 95)
                        idx = '0;
                    else
                        idx = 11'($urandom);
                end
                else if (sel < 92)
                begin
                    op = OP_RD_ENTRY;
                    if (tot > 0 && sel2 < 75)
                        idx = 11'($urandom_range(tot - 1, 0));
                    else if (tot > 0 && sel2 < 85)
                        idx = 11'(tot - 1);
                    else if (sel2 < 92)
                        idx = 11'(tot);
                    else
                        idx = 11'($urandom);
                end
                else if (sel < 98)
                begin
                    op = OP_NONE;
                    idx = 11'($urandom);
                end
                else
                begin
                    // a lone load reopens the loading phase
                    op = OP_LOAD;
                    idx = 11'($urandom);
                end
                send_word(op, 9'($urandom), {$urandom, $urandom}, 1'b0, idx, 1'b0, STS_OK);
            end
            ph++;
        end

        // Drain, then give stray words time to show up
        settle();
        repeat (32) @(posedge clk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
